// ===== sv/sxc_pkg.sv =====
// Shared types, widths, gamma tables and matrix coefficients of the sRGB/XYZ converter.
package sxc_pkg;

    // Fixed-point formats.
    localparam int XYZ_FRAC_BITS     = 8;
    localparam int LINEAR_INDEX_BITS = 12;
    localparam int COEF_FRAC_BITS    = 14;

    localparam int CH_W   = 8;
    localparam int XYZ_W  = 15;
    localparam int LIN_W  = 16;
    localparam int CODES  = 256;
    localparam int CODE_W = 8;
    localparam int OPD_W  = LIN_W + 1;
    localparam int COEF_W = COEF_FRAC_BITS + 3;
    localparam int PROD_W = COEF_W + OPD_W;
    localparam int ACC_W  = PROD_W + 2;

    // Reverse normalisation: u = floor(|acc|/2^(COEF+XYZ-15))+50, linear = floor(u/100).
    localparam int LIN_SHIFT = COEF_FRAC_BITS + XYZ_FRAC_BITS - 15;
    localparam int U_W       = 22;
    // Linear values drop their low bits down to the index resolution.
    localparam int Q_DROP    = (LINEAR_INDEX_BITS < 15) ? 15 - LINEAR_INDEX_BITS : 0;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    typedef enum logic {
        OP_TO_XYZ = 1'b0,
        OP_TO_RGB = 1'b1
    } t_op;

    typedef logic [CODES-1:0][LIN_W-1:0] t_gamma_tab;
    typedef logic [8:0][COEF_W-1:0]      t_coef_set;

    // Matrix constants scaled by 10^7, row-major.
    localparam longint FWD_K [9] = '{
        64'sd4124530, 64'sd3575800, 64'sd1804230,
        64'sd2126710, 64'sd7151600, 64'sd721690,
        64'sd193340,  64'sd1191930, 64'sd9502270
    };
    localparam longint REV_K [9] = '{
        64'sd32404542, -64'sd15371385, -64'sd4985314,
        -64'sd9692660, 64'sd18760108,  64'sd415560,
        64'sd556434,   -64'sd2040259,  64'sd10572252
    };

    // Decode curve at half-code h (v = h/510), result in Q1.15.
    function automatic logic [LIN_W-1:0] decode_half(input logic [63:0] h);
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        logic [63:0] result;
        int          i;
        if (h < 64'd21) begin
            result = (64'd3276800 * h + 64'd329460) / 64'd658920;
        end else begin
            r  = (((64'd1000 * h + 64'd28050) << 30) + 64'd269025) / 64'd538050;
            s  = (r * r + Q30_HALF) >> 30;
            lo = 64'd0;
            hi = Q30_ONE;
            while (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                p   = mid;
                for (i = 0; i < 4; i++) begin
                    p = (p * mid + Q30_HALF) >> 30;
                end
                if (p <= s) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
            result = (s * lo + (64'd1 << 44)) >> 45;
        end
        return LIN_W'(result);
    endfunction

    function automatic t_gamma_tab build_lin_tab();
        t_gamma_tab tab;
        int         c;
        for (c = 0; c < CODES; c++) begin
            tab[c] = decode_half(64'(2 * c));
        end
        return tab;
    endfunction

    // Entry c is the smallest linear value that encodes to code c.
    function automatic t_gamma_tab build_thr_tab();
        t_gamma_tab tab;
        int         c;
        tab[0] = '0;
        for (c = 1; c < CODES; c++) begin
            tab[c] = decode_half(64'(2 * c - 1));
        end
        return tab;
    endfunction

    function automatic t_coef_set build_coefs(input logic rev);
        t_coef_set coefs;
        longint    k;
        longint    m;
        longint    v;
        int        i;
        for (i = 0; i < 9; i++) begin
            k = rev ? REV_K[i] : FWD_K[i];
            m = (k < 0) ? -k : k;
            v = ((m << COEF_FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
            if (k < 0) begin
                v = -v;
            end
            coefs[i] = COEF_W'(v);
        end
        return coefs;
    endfunction

    localparam t_gamma_tab LIN_TAB  = build_lin_tab();
    localparam t_gamma_tab THR_TAB  = build_thr_tab();
    localparam t_coef_set  FWD_COEF = build_coefs(1'b0);
    localparam t_coef_set  REV_COEF = build_coefs(1'b1);

    typedef struct packed {
        t_op                        op;
        logic [2:0][CH_W-1:0]       rgb;
        logic [2:0][XYZ_W-1:0]      xyz;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_in_beat;

    typedef struct packed {
        logic                   valid;
        t_item                  item;
        logic [2:0][ACC_W-1:0]  acc;
    } t_acc_beat;

    typedef struct packed {
        logic                   valid;
        t_item                  item;
        logic [2:0][XYZ_W-1:0]  xyz_calc;
        logic [2:0][LIN_W-1:0]  q;
        logic                   gamut;
        logic [2:0][CODE_W-1:0] code;
    } t_enc_beat;

endpackage

// ===== sv/sxc_front.sv =====
// Linearisation lookup, shared 3x3 matrix multipliers and row sums.
module sxc_front
    import sxc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_beat,
    output t_acc_beat o_beat
);

    typedef struct packed {
        logic                   valid;
        t_item                  item;
        logic [2:0][OPD_W-1:0]  opd;
    } t_opd_beat;

    typedef struct packed {
        logic                   valid;
        t_item                  item;
        logic [8:0][PROD_W-1:0] prod;
    } t_prod_beat;

    t_opd_beat  r_opd;
    t_opd_beat  n_opd;
    t_prod_beat r_prod;
    t_prod_beat n_prod;
    t_acc_beat  r_acc;
    t_acc_beat  n_acc;

    // Forward mode multiplies linear light, reverse mode multiplies XYZ.
    always_comb begin
        n_opd.valid = i_beat.valid;
        n_opd.item  = i_beat.item;
        for (int c = 0; c < 3; c++) begin
            if (i_beat.item.op == OP_TO_RGB) begin
                n_opd.opd[c] = OPD_W'(i_beat.item.xyz[c]);
            end else begin
                n_opd.opd[c] = OPD_W'(LIN_TAB[i_beat.item.rgb[c]]);
            end
        end
    end

    always_comb begin
        logic signed [COEF_W-1:0] coef;
        logic signed [OPD_W-1:0]  opd;
        logic signed [PROD_W-1:0] prod;
        n_prod.valid = r_opd.valid;
        n_prod.item  = r_opd.item;
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                if (r_opd.item.op == OP_TO_RGB) begin
                    coef = $signed(REV_COEF[3 * row + col]);
                end else begin
                    coef = $signed(FWD_COEF[3 * row + col]);
                end
                opd  = $signed(r_opd.opd[col]);
                prod = coef * opd;
                n_prod.prod[3 * row + col] = prod;
            end
        end
    end

    always_comb begin
        logic signed [ACC_W-1:0] sum;
        n_acc.valid = r_prod.valid;
        n_acc.item  = r_prod.item;
        for (int row = 0; row < 3; row++) begin
            sum = $signed(r_prod.prod[3 * row]) + $signed(r_prod.prod[3 * row + 1])
                + $signed(r_prod.prod[3 * row + 2]);
            n_acc.acc[row] = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opd.valid  <= 1'b0;
            r_prod.valid <= 1'b0;
            r_acc.valid  <= 1'b0;
        end else begin
            r_opd  <= n_opd;
            r_prod <= n_prod;
            r_acc  <= n_acc;
        end
    end

    assign o_beat = r_acc;

endmodule

// ===== sv/sxc_scale.sv =====
// Scaling to XYZ units in forward mode; normalisation, clamping and divide by 100 in reverse.
module sxc_scale
    import sxc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_acc_beat i_beat,
    output t_enc_beat o_beat
);

    localparam int              T_W     = ACC_W + 8 + XYZ_FRAC_BITS;
    localparam int              V_SHIFT = COEF_FRAC_BITS + 15;
    localparam logic [T_W-1:0]  V_RND   = T_W'(1) << (COEF_FRAC_BITS + 14);
    localparam logic [T_W-1:0]  V_MAX   = T_W'(32767);
    localparam logic [ACC_W:0]  U_RND   = (ACC_W + 1)'(50) << LIN_SHIFT;
    localparam logic [ACC_W:0]  U_OVER  = (ACC_W + 1)'(3276900);
    localparam logic [ACC_W:0]  U_NZ    = (ACC_W + 1)'(100);
    localparam logic [U_W-1:0]  U_MAX   = U_W'(3276800);
    localparam int              R_SHIFT = 29;
    localparam int              R_W     = 23;
    localparam logic [R_W-1:0]  RECIP   = R_W'(5368710);

    typedef struct packed {
        logic                   valid;
        t_item                  item;
        logic [2:0][XYZ_W-1:0]  xyz_calc;
        logic [2:0][U_W-1:0]    u;
        logic                   gamut;
    } t_div_beat;

    t_div_beat r_div;
    t_div_beat n_div;
    t_enc_beat r_enc;
    t_enc_beat n_enc;

    always_comb begin
        logic             neg;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] pos;
        logic [T_W-1:0]   t;
        logic [T_W-1:0]   v;
        logic [ACC_W:0]   u_full;
        n_div.valid = i_beat.valid;
        n_div.item  = i_beat.item;
        n_div.gamut = 1'b0;
        for (int c = 0; c < 3; c++) begin
            neg = i_beat.acc[c][ACC_W-1];
            // Forward: times 100, up to XYZ units, rounded half up, saturated.
            pos = neg ? '0 : i_beat.acc[c];
            t   = (T_W'(pos) << 6) + (T_W'(pos) << 5) + (T_W'(pos) << 2);
            v   = ((t << XYZ_FRAC_BITS) + V_RND) >> V_SHIFT;
            n_div.xyz_calc[c] = (v > V_MAX) ? XYZ_W'(V_MAX) : XYZ_W'(v);
            // Reverse: magnitude in hundredths of Q1.15, clamped to the range 0 to 1.
            mag    = neg ? ACC_W'(-i_beat.acc[c]) : i_beat.acc[c];
            u_full = ((ACC_W + 1)'(mag) + U_RND) >> LIN_SHIFT;
            if (neg) begin
                n_div.u[c] = '0;
                if (u_full >= U_NZ && i_beat.item.op == OP_TO_RGB) begin
                    n_div.gamut = 1'b1;
                end
            end else if (u_full >= U_OVER) begin
                n_div.u[c] = U_MAX;
                if (i_beat.item.op == OP_TO_RGB) begin
                    n_div.gamut = 1'b1;
                end
            end else begin
                n_div.u[c] = U_W'(u_full);
            end
        end
    end

    // Divide by 100 through a reciprocal that is exact for every u below 2^22.
    always_comb begin
        logic [U_W+R_W-1:0] prod;
        logic [LIN_W-1:0]   lin;
        n_enc.valid    = r_div.valid;
        n_enc.item     = r_div.item;
        n_enc.xyz_calc = r_div.xyz_calc;
        n_enc.gamut    = r_div.gamut;
        n_enc.code     = '0;
        for (int c = 0; c < 3; c++) begin
            prod       = r_div.u[c] * RECIP;
            lin        = LIN_W'(prod >> R_SHIFT);
            n_enc.q[c] = (lin >> Q_DROP) << Q_DROP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
            r_enc.valid <= 1'b0;
        end else begin
            r_div <= n_div;
            r_enc <= n_enc;
        end
    end

    assign o_beat = r_enc;

endmodule

// ===== sv/sxc_encode.sv =====
// Pipelined binary search of the encode thresholds, one code bit per stage.
module sxc_encode
    import sxc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_enc_beat i_beat,
    output t_enc_beat o_beat
);

    t_enc_beat r_pipe  [CODE_W];
    t_enc_beat w_stage [CODE_W+1];

    assign w_stage[0] = i_beat;

    for (genvar s = 0; s < CODE_W; s++) begin : g_step
        localparam logic [CODE_W-1:0] STEP_BIT = CODE_W'(1) << (CODE_W - 1 - s);

        t_enc_beat n_step;

        // Thresholds rise with the code, so keep the bit when its threshold is reached.
        always_comb begin
            logic [CODE_W-1:0] cand;
            n_step = w_stage[s];
            for (int c = 0; c < 3; c++) begin
                cand = w_stage[s].code[c] | STEP_BIT;
                if (THR_TAB[cand] <= w_stage[s].q[c]) begin
                    n_step.code[c] = cand;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[s].valid <= 1'b0;
            end else begin
                r_pipe[s] <= n_step;
            end
        end

        assign w_stage[s+1] = r_pipe[s];
    end

    assign o_beat = w_stage[CODE_W];

endmodule

// ===== sv/srgb_xyz_converter.sv =====
// Top level of the sRGB to CIE XYZ (D65) converter, both directions in one pipeline.
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  ------------------------------------
//  command   start, busy, i_operation, i_red_in,     beat taken when start high, busy low
//            i_green_in, i_blue_in, i_x_in, i_y_in,
//            i_z_in
//  result    o_done, o_red_out, o_green_out,         single-cycle beats, no back-pressure
//            o_blue_out, o_x_out, o_y_out, o_z_out,
//            o_out_of_gamut
//
// One beat is taken in every clock cycle in which start is high; busy is held low.
// The result of a beat is shown on the result ports with o_done high, and is taken at the
// edge that ends the cycle in which it is shown. The depth is set by the eight-stage
// threshold search of the encode gamma, plus the input register, three matrix stages, two
// scaling stages and the output register.
// Synchronous reset clears only the valid bits of the pipeline; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds and nothing is dropped or repeated.
module srgb_xyz_converter
    import sxc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [CH_W-1:0]   i_red_in,
    input  logic [CH_W-1:0]   i_green_in,
    input  logic [CH_W-1:0]   i_blue_in,
    input  logic [XYZ_W-1:0]  i_x_in,
    input  logic [XYZ_W-1:0]  i_y_in,
    input  logic [XYZ_W-1:0]  i_z_in,
    output logic              o_done,
    output logic [CH_W-1:0]   o_red_out,
    output logic [CH_W-1:0]   o_green_out,
    output logic [CH_W-1:0]   o_blue_out,
    output logic [XYZ_W-1:0]  o_x_out,
    output logic [XYZ_W-1:0]  o_y_out,
    output logic [XYZ_W-1:0]  o_z_out,
    output logic              o_out_of_gamut
);

    typedef struct packed {
        logic                   valid;
        logic [2:0][CH_W-1:0]   rgb;
        logic [2:0][XYZ_W-1:0]  xyz;
        logic                   gamut;
    } t_result;

    t_in_beat  r_in;
    t_in_beat  n_in;
    t_acc_beat w_acc;
    t_enc_beat w_lin;
    t_enc_beat w_code;
    t_result   r_out;
    t_result   n_out;

    // The pipeline advances every cycle, so a new command beat is always welcome.
    assign busy = 1'b0;

    always_comb begin
        n_in.valid       = start && !busy;
        n_in.item.op     = t_op'(i_operation);
        n_in.item.rgb[0] = i_red_in;
        n_in.item.rgb[1] = i_green_in;
        n_in.item.rgb[2] = i_blue_in;
        n_in.item.xyz[0] = i_x_in;
        n_in.item.xyz[1] = i_y_in;
        n_in.item.xyz[2] = i_z_in;
    end

    sxc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (r_in),
        .o_beat  (w_acc)
    );

    sxc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_acc),
        .o_beat  (w_lin)
    );

    sxc_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_lin),
        .o_beat  (w_code)
    );

    // The channels that were not computed echo the input of the beat.
    always_comb begin
        n_out.valid = w_code.valid;
        if (w_code.item.op == OP_TO_RGB) begin
            n_out.rgb   = w_code.code;
            n_out.xyz   = w_code.item.xyz;
            n_out.gamut = w_code.gamut;
        end else begin
            n_out.rgb   = w_code.item.rgb;
            n_out.xyz   = w_code.xyz_calc;
            n_out.gamut = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid  <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_in  <= n_in;
            r_out <= n_out;
        end
    end

    assign o_done         = r_out.valid;
    assign o_red_out      = r_out.rgb[0];
    assign o_green_out    = r_out.rgb[1];
    assign o_blue_out     = r_out.rgb[2];
    assign o_x_out        = r_out.xyz[0];
    assign o_y_out        = r_out.xyz[1];
    assign o_z_out        = r_out.xyz[2];
    assign o_out_of_gamut = r_out.gamut;

endmodule

// ===== tb/tb_srgb_xyz_converter.sv =====
// Self-checking testbench of the sRGB/XYZ converter: directed table, then random colours.
module tb_srgb_xyz_converter
    import sxc_pkg::*;
();

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1630;
    // No idling at all during the last stretch, so the pipeline runs full.
    localparam int CALM_TAIL      = 300;
    // Watch for stray results after the drain, with ample margin over the pipeline depth.
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int NUM_DIRECTED   = 20;
    // Linear values lose their low bits down to the resolution of the encode index.
    localparam int LIN_DROP       = (LINEAR_INDEX_BITS < 15) ? 15 - LINEAR_INDEX_BITS : 0;

    // D65 matrices, published decimals scaled by ten million, row-major.
    localparam longint RGB2XYZ_E7 [9] = '{
        4124530, 3575800, 1804230,
        2126710, 7151600, 721690,
        193340,  1191930, 9502270
    };
    localparam longint XYZ2RGB_E7 [9] = '{
        32404542, -15371385, -4985314,
        -9692660, 18760108,  415560,
        556434,   -2040259,  10572252
    };

    typedef struct packed {
        t_op              op;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [XYZ_W-1:0] x;
        logic [XYZ_W-1:0] y;
        logic [XYZ_W-1:0] z;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [XYZ_W-1:0] x;
        logic [XYZ_W-1:0] y;
        logic [XYZ_W-1:0] z;
        logic             gamut;
    } t_conv_result;

    // A row either carries its expected result typed in, or leaves it to the predictor.
    typedef struct packed {
        t_pixel       stim;
        logic         typed;
        t_conv_result want;
    } t_directed_row;

    localparam t_conv_result NO_COLOUR = '0;

    // Black in either direction must give all zeros, whatever the unused fields hold.
    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{'{OP_TO_XYZ, 8'd0,   8'd0,   8'd0,   15'd32767, 15'd32767, 15'd32767}, 1'b1, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd255, 8'd255, 8'd255, 15'd0,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd255, 8'd0,   8'd0,   15'd0,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd0,   8'd255, 8'd0,   15'd0,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd0,   8'd0,   8'd255, 15'd0,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd10,  8'd10,  8'd10,  15'd0,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd11,  8'd11,  8'd11,  15'd0,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd1,   8'd128, 8'd254, 15'd0,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd255, 8'd255, 8'd255, 15'd0,     15'd0,     15'd0    }, 1'b1, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd32767, 15'd32767, 15'd32767}, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd32767, 15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd0,     15'd32767, 15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd0,     15'd0,     15'd32767}, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd24332, 15'd25600, 15'd27874}, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd1,     15'd1,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd1,     15'd0,     15'd0    }, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd12166, 15'd12800, 15'd13937}, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd0,   8'd0,   8'd0,   15'd16384, 15'd0,     15'd16384}, 1'b0, NO_COLOUR},
        '{'{OP_TO_XYZ, 8'd128, 8'd64,  8'd32,  15'd21845, 15'd10922, 15'd5461 }, 1'b0, NO_COLOUR},
        '{'{OP_TO_RGB, 8'd170, 8'd85,  8'd170, 15'd21845, 15'd10922, 15'd5461 }, 1'b0, NO_COLOUR}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_operation;
    logic [CH_W-1:0]  i_red_in;
    logic [CH_W-1:0]  i_green_in;
    logic [CH_W-1:0]  i_blue_in;
    logic [XYZ_W-1:0] i_x_in;
    logic [XYZ_W-1:0] i_y_in;
    logic [XYZ_W-1:0] i_z_in;
    logic             o_done;
    logic [CH_W-1:0]  o_red_out;
    logic [CH_W-1:0]  o_green_out;
    logic [CH_W-1:0]  o_blue_out;
    logic [XYZ_W-1:0] o_x_out;
    logic [XYZ_W-1:0] o_y_out;
    logic [XYZ_W-1:0] o_z_out;
    logic             o_out_of_gamut;

    // Gamma tables and Q3.14 matrices of the predictor, filled before reset is released.
    logic [LIN_W-1:0] lin_lut [CODES];
    logic [LIN_W-1:0] enc_thr [CODES];
    longint           rgb2xyz_coef [9];
    longint           xyz2rgb_coef [9];

    t_conv_result     pending_colours [$];
    int               mismatch_count = 0;

    srgb_xyz_converter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_x_in         (i_x_in),
        .i_y_in         (i_y_in),
        .i_z_in         (i_z_in),
        .o_done         (o_done),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_z_out        (o_z_out),
        .o_out_of_gamut (o_out_of_gamut)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Q30 product, rounded half up.
    function automatic longint unsigned q30_product(input longint unsigned a,
                                                    input longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // sRGB decode curve at half-code h (the code value is h/510), giving Q1.15.
    // Below the knee it is the straight segment; above it the 2.4 power is taken as the
    // square of the base times its fifth root, the root found by bisection.
    function automatic logic [LIN_W-1:0] srgb_to_linear(input longint unsigned h);
        longint unsigned base;
        longint unsigned sq;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned pw;
        if (h < 64'd21) begin
            return LIN_W'((64'd3276800 * h + 64'd329460) / 64'd658920);
        end
        base = (((64'd1000 * h + 64'd28050) << 30) + 64'd269025) / 64'd538050;
        sq   = q30_product(base, base);
        lo   = 64'd0;
        hi   = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            pw  = mid;
            repeat (4) pw = q30_product(pw, mid);
            if (pw <= sq) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return LIN_W'((sq * lo + (64'd1 << 44)) >> 45);
    endfunction

    // Rounds a decimal constant (times ten million) to the coefficient format, half away
    // from zero.
    function automatic longint coef_from_e7(input longint k);
        longint mag;
        longint v;
        mag = (k < 0) ? -k : k;
        v   = ((mag << COEF_FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
        return (k < 0) ? -v : v;
    endfunction

    // Expected result of one colour beat.
    function automatic t_conv_result convert_colour(input t_pixel p);
        t_conv_result     res;
        logic [LIN_W-1:0] lin [3];
        longint           xyz [3];
        logic [XYZ_W-1:0] xyz_calc [3];
        logic [CH_W-1:0]  code [3];
        longint           acc;
        longint unsigned  mag;
        longint unsigned  v;
        longint unsigned  den;
        int               count;
        logic             gamut;
        int               i;
        int               c;
        gamut = 1'b0;
        if (p.op == OP_TO_XYZ) begin
            lin[0] = lin_lut[p.red];
            lin[1] = lin_lut[p.green];
            lin[2] = lin_lut[p.blue];
            for (i = 0; i < 3; i++) begin
                acc = rgb2xyz_coef[3*i]     * longint'(lin[0])
                    + rgb2xyz_coef[3*i + 1] * longint'(lin[1])
                    + rgb2xyz_coef[3*i + 2] * longint'(lin[2]);
                mag = (acc < 0) ? 64'd0 : acc;
                v   = (((64'd100 * mag) << XYZ_FRAC_BITS) + (64'd1 << (COEF_FRAC_BITS + 14)))
                      >> (COEF_FRAC_BITS + 15);
                xyz_calc[i] = (v > 64'd32767) ? '1 : XYZ_W'(v);
            end
            res = '{p.red, p.green, p.blue, xyz_calc[0], xyz_calc[1], xyz_calc[2], 1'b0};
        end else begin
            xyz[0] = longint'(p.x);
            xyz[1] = longint'(p.y);
            xyz[2] = longint'(p.z);
            den    = 64'd100 << (COEF_FRAC_BITS + XYZ_FRAC_BITS);
            for (i = 0; i < 3; i++) begin
                acc = xyz2rgb_coef[3*i] * xyz[0] + xyz2rgb_coef[3*i + 1] * xyz[1]
                    + xyz2rgb_coef[3*i + 2] * xyz[2];
                mag = (acc < 0) ? -acc : acc;
                v   = (mag * 64'd32768 + den / 2) / den;
                count = 0;
                if (acc < 0) begin
                    // Only a negative value that survives rounding counts as clamped.
                    if (v != 0) begin
                        gamut = 1'b1;
                    end
                end else begin
                    if (v > 64'd32768) begin
                        gamut = 1'b1;
                        v     = 64'd32768;
                    end
                    v = (v >> LIN_DROP) << LIN_DROP;
                    for (c = 1; c < CODES; c++) begin
                        if (v >= enc_thr[c]) begin
                            count++;
                        end
                    end
                end
                code[i] = CH_W'(count);
            end
            res = '{code[0], code[1], code[2], p.x, p.y, p.z, gamut};
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] pick_channel_edge();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [XYZ_W-1:0] pick_xyz_edge();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return XYZ_W'($urandom);
        endcase
    endfunction

    // Presents one beat, waits until it is taken, records what it should produce, and then
    // optionally leaves start low for a number of cycles.
    task automatic push_pixel(input t_pixel p, input logic typed, input t_conv_result want,
                              input int gap);
        start       <= 1'b1;
        i_operation <= p.op;
        i_red_in    <= p.red;
        i_green_in  <= p.green;
        i_blue_in   <= p.blue;
        i_x_in      <= p.x;
        i_y_in      <= p.y;
        i_z_in      <= p.z;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_colours.push_back(typed ? want : convert_colour(p));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_colours();
        start <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_pixel       px;
        t_conv_result round_trip;
        int           i;
        int           c;
        int           kind;
        int           gap;
        logic         gaps_on;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_TO_XYZ;
        i_red_in    <= '0;
        i_green_in  <= '0;
        i_blue_in   <= '0;
        i_x_in      <= '0;
        i_y_in      <= '0;
        i_z_in      <= '0;

        for (c = 0; c < CODES; c++) begin
            lin_lut[c] = srgb_to_linear(longint'(2 * c));
            enc_thr[c] = (c == 0) ? '0 : srgb_to_linear(longint'(2 * c - 1));
        end
        for (c = 0; c < 9; c++) begin
            rgb2xyz_coef[c] = coef_from_e7(RGB2XYZ_E7[c]);
            xyz2rgb_coef[c] = coef_from_e7(XYZ2RGB_E7[c]);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++) begin
            push_pixel(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want, 0);
        end
        drain_colours();

        gaps_on = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            // Idling is switched on and off in stretches so that some runs are back to back.
            if (i % 64 == 0) begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (i == RANDOM_ITEMS / 2) begin
                drain_colours();
            end
            // The fields that the chosen direction ignores always carry noise.
            px.red   = CH_W'($urandom);
            px.green = CH_W'($urandom);
            px.blue  = CH_W'($urandom);
            px.x     = XYZ_W'($urandom);
            px.y     = XYZ_W'($urandom);
            px.z     = XYZ_W'($urandom);
            kind     = $urandom_range(0, 99);
            if (kind < 45) begin
                px.op = OP_TO_XYZ;
                if (kind < 10) begin
                    px.red   = pick_channel_edge();
                    px.green = pick_channel_edge();
                    px.blue  = pick_channel_edge();
                end
            end else if (kind < 70) begin
                // A colour that lies inside the gamut: the forward image of a random sRGB.
                px.op      = OP_TO_XYZ;
                round_trip = convert_colour(px);
                px.op      = OP_TO_RGB;
                px.x       = round_trip.x;
                px.y       = round_trip.y;
                px.z       = round_trip.z;
                px.red     = CH_W'($urandom);
            end else if (kind < 85) begin
                // Tiny values, where negative results round either to zero or just past it.
                px.op = OP_TO_RGB;
                px.x  = XYZ_W'($urandom_range(0, 15));
                px.y  = XYZ_W'($urandom_range(0, 15));
                px.z  = XYZ_W'($urandom_range(0, 15));
            end else if (kind < 93) begin
                px.op = OP_TO_RGB;
                px.x  = pick_xyz_edge();
                px.y  = pick_xyz_edge();
                px.z  = pick_xyz_edge();
            end else begin
                px.op = OP_TO_RGB;
            end
            gap = 0;
            if (gaps_on && i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 9);
            end
            push_pixel(px, 1'b0, NO_COLOUR, gap);
        end

        drain_colours();
        // Any stray result after the last expected one would show up in this window.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_srgb_xyz_converter OK");
        end else begin
            $display("tb_srgb_xyz_converter NOT OK");
        end
        $finish;
    end

    // Results are taken at the edge that ends their cycle; the values read here are the ones
    // that held during that cycle.
    always @(posedge i_clk) begin
        t_conv_result got;
        t_conv_result want;
        if (i_rst_n && o_done) begin
            got = '{o_red_out, o_green_out, o_blue_out, o_x_out, o_y_out, o_z_out,
                    o_out_of_gamut};
            if (pending_colours.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none,", $time,
                         " got rgb=%0d,%0d,%0d xyz=%0d,%0d,%0d gamut=%0b",
                         got.red, got.green, got.blue, got.x, got.y, got.z, got.gamut);
            end else begin
                want = pending_colours.pop_front();
                if (got.red !== want.red || got.green !== want.green
                    || got.blue !== want.blue || got.x !== want.x || got.y !== want.y
                    || got.z !== want.z || got.gamut !== want.gamut) begin
                    mismatch_count++;
                    $display("%0t: result mismatch,", $time,
                             " expected rgb=%0d,%0d,%0d xyz=%0d,%0d,%0d gamut=%0b,",
                             want.red, want.green, want.blue, want.x, want.y, want.z,
                             want.gamut,
                             " got rgb=%0d,%0d,%0d xyz=%0d,%0d,%0d gamut=%0b",
                             got.red, got.green, got.blue, got.x, got.y, got.z,
                             got.gamut);
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_srgb_xyz_converter NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sxc_pkg.sv
sv/sxc_front.sv
sv/sxc_scale.sv
sv/sxc_encode.sv
sv/srgb_xyz_converter.sv
tb/tb_srgb_xyz_converter.sv
